@@ rtl/core/ioset_pkg.sv @@
// ioset_pkg: operation codes and field types of the insertion ordered set
// no dependencies; used by the channel interfaces and the top level

package ioset_pkg;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef logic        [OP_W-1:0]    op_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [INDEX_W-1:0] index_t;
  typedef logic        [COUNT_W-1:0] count_t;

  localparam op_t OP_ADD      = 3'd0;
  localparam op_t OP_REMOVE   = 3'd1;
  localparam op_t OP_CONTAINS = 3'd2;
  localparam op_t OP_CLEAR    = 3'd3;
  localparam op_t OP_READ     = 3'd4;

endpackage

@@ rtl/core/ioset_in_if.sv @@
// ioset_in_if: request channel carrying one operation word
// depends on ioset_pkg

interface ioset_in_if;
  import ioset_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  value_t value;
  index_t index;

  modport source (output valid, output operation, output value, output index, input ready);
  modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

@@ rtl/core/ioset_out_if.sv @@
// ioset_out_if: response channel carrying one result word
// depends on ioset_pkg

interface ioset_out_if;
  import ioset_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  value_t read_value;
  count_t member_count;
  logic   set_full;

  modport source (output valid, output hit, output read_value, output member_count,
                  output set_full, input ready);
  modport sink   (input valid, input hit, input read_value, input member_count,
                  input set_full, output ready);
endinterface

@@ rtl/core/insertion_ordered_int_set.sv @@
// insertion_ordered_int_set: set of distinct integers kept in insertion order
// depends on ioset_pkg, ioset_in_if, ioset_out_if
//
//   channel | dir | word
//   --------+-----+--------------------------------------------------
//   req     | in  | operation, value, index
//   rsp     | out | hit, read_value, member_count, set_full
//
// one request at a time; the member array is a one-port-read, one-port-write
// synchronous RAM, one access per port per cycle. after the accepting cycle,
// add and contains scan below the count, stopping on a hit; remove scans to
// the match and shifts later entries down; read waits for the RAM read;
// clear and spare codes go to the result, which moves into the output
// register. rst clears the count and control; the RAM is not cleared (only
// entries below the count are read). a result waiting in the output register
// does not block the next request; a second finished result waits for it.

module insertion_ordered_int_set #(
  parameter int DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  ioset_in_if.sink  req,
  ioset_out_if.source rsp
);
  import ioset_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] count;
  op_t           op_r;
  value_t        val_r;

  // scan pointers
  logic [CW-1:0] ptr;
  logic          chk_valid;
  logic [AW-1:0] chk_addr;

  // shift pointers
  logic [CW-1:0] sh_rd;
  logic          sh_wv;
  logic [AW-1:0] sh_wa;

  // pending result and output register
  logic   res_hit;
  value_t res_rd;
  logic   out_valid;
  logic   out_load;
  logic   out_hit;
  value_t out_rd;
  count_t out_count;
  logic   out_full;

  // member RAM
  value_t        mem [DEPTH];
  value_t        mem_q;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  value_t        mem_wd;

  logic            match;
  logic            scan_more;
  logic            has_room;
  logic            idx_ok;
  logic [CW+5:0]   idx_ext;
  logic [CW+5:0]   cnt_ext;
  logic [CW+6:0]   cnt_wide;

  assign req.ready = (state == S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.read_value   = out_rd;
  assign rsp.member_count = out_count;
  assign rsp.set_full     = out_full;

  assign match     = chk_valid && (mem_q == val_r);
  assign scan_more = (ptr < count);
  assign has_room  = (count < CW'(DEPTH));
  assign idx_ext   = {{CW{1'b0}}, req.index};
  assign cnt_ext   = {{INDEX_W{1'b0}}, count};
  assign idx_ok    = (idx_ext < cnt_ext);
  assign cnt_wide  = {{COUNT_W{1'b0}}, count};
  assign out_load  = (state == S_HOLD) && (!out_valid || rsp.ready);

  // RAM port control
  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = val_r;
    case (state)
      S_IDLE: begin
        if (req.valid && (req.operation == OP_READ) && idx_ok) begin
          mem_re = 1'b1;
          mem_ra = idx_ext[AW-1:0];
        end
      end
      S_SCAN: begin
        if (!match && scan_more) begin
          mem_re = 1'b1;
          mem_ra = ptr[AW-1:0];
        end else if (!match && (op_r == OP_ADD) && has_room) begin
          mem_we = 1'b1;
          mem_wa = count[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (sh_wv) begin
          mem_we = 1'b1;
          mem_wa = sh_wa;
          mem_wd = mem_q;
        end
        if (sh_rd < count) begin
          mem_re = 1'b1;
          mem_ra = sh_rd[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // member RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      sh_wv     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register valid
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r      <= req.operation;
            val_r     <= req.value;
            res_hit   <= 1'b0;
            res_rd    <= '0;
            ptr       <= '0;
            chk_valid <= 1'b0;
            case (req.operation)
              OP_ADD, OP_REMOVE, OP_CONTAINS: state <= S_SCAN;
              OP_CLEAR: begin
                count <= '0;
                state <= S_HOLD;
              end
              OP_READ: state <= idx_ok ? S_RDWAIT : S_HOLD;
              default: state <= S_HOLD;
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            chk_valid <= 1'b0;
            case (op_r)
              OP_REMOVE: begin
                sh_rd <= CW'(chk_addr) + CW'(1);
                sh_wv <= 1'b0;
                state <= S_SHIFT;
              end
              OP_CONTAINS: begin
                res_hit <= 1'b1;
                state   <= S_HOLD;
              end
              default: state <= S_HOLD;
            endcase
          end else if (scan_more) begin
            chk_valid <= 1'b1;
            chk_addr  <= ptr[AW-1:0];
            ptr       <= ptr + CW'(1);
          end else begin
            // value absent
            chk_valid <= 1'b0;
            if ((op_r == OP_ADD) && has_room) begin
              count   <= count + CW'(1);
              res_hit <= 1'b1;
            end
            state <= S_HOLD;
          end
        end
        S_SHIFT: begin
          if (sh_rd < count) begin
            sh_wv <= 1'b1;
            sh_wa <= AW'(sh_rd - CW'(1));
            sh_rd <= sh_rd + CW'(1);
          end else begin
            sh_wv <= 1'b0;
            if (!sh_wv) begin
              count   <= count - CW'(1);
              res_hit <= 1'b1;
              state   <= S_HOLD;
            end
          end
        end
        S_RDWAIT: begin
          res_hit <= 1'b1;
          res_rd  <= mem_q;
          state   <= S_HOLD;
        end
        S_HOLD: begin
          if (out_load) begin
            out_hit   <= res_hit;
            out_rd    <= res_rd;
            out_count <= cnt_wide[COUNT_W-1:0];
            out_full  <= (count == CW'(DEPTH));
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count stays within the array
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("member count above depth");

  // count moves by one step or to zero
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)) ||
      (count == '0))
    else $error("member count jumped");

  // RAM is written only while scanning or shifting
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN) || (state == S_SHIFT))
    else $error("RAM write outside scan or shift");

  // shift writes always trail the read pointer
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && sh_wv) |-> (CW'(sh_wa) < sh_rd))
    else $error("shift write ahead of read");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while busy");

endmodule
